>>> sv/mia_pkg.sv
`timescale 1ns / 1ps

package mia_pkg;

	localparam int DataW = 32;
	localparam int DivSteps = DataW;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_ADDI = 3'd1,
		OP_SUB  = 3'd2,
		OP_MULT = 3'd3,
		OP_DIV  = 3'd4,
		OP_AND  = 3'd5,
		OP_OR   = 3'd6,
		OP_XOR  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_SIMPLE = 2'd0,
		K_MULT   = 2'd1,
		K_DIV    = 2'd2
	} kind_t;

	// Classified request as it waits in the queue.
	typedef struct packed {
		kind_t            kind;
		logic [DataW-1:0] res;
		status_t          st;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic             neg_q;
		logic             neg_r;
	} item_t;

	// Working state of one request inside the execution pipeline.
	typedef struct packed {
		kind_t              kind;
		logic [DataW-1:0]   res;
		status_t            st;
		logic [2*DataW-1:0] prod;
		logic [DataW-1:0]   rem;
		logic [DataW-1:0]   dq;
		logic [DataW-1:0]   dvs;
		logic               neg_q;
		logic               neg_r;
	} pipe_t;

endpackage

>>> sv/mia_if.sv
`timescale 1ns / 1ps

interface mia_in_if;
	import mia_pkg::*;
	logic             valid;
	logic             ready;
	logic [2:0]       action;
	logic [DataW-1:0] operand_a;
	logic [DataW-1:0] operand_b;

	modport source (output valid, action, operand_a, operand_b, input ready);
	modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface mia_out_if;
	import mia_pkg::*;
	logic             valid;
	logic             ready;
	logic [DataW-1:0] result;
	logic [DataW-1:0] hi_word;
	logic [DataW-1:0] lo_word;
	logic [1:0]       status;

	modport source (output valid, result, hi_word, lo_word, status, input ready);
	modport sink (input valid, result, hi_word, lo_word, status, output ready);
endinterface

>>> sv/mia_front.sv
`timescale 1ns / 1ps

module mia_front
	import mia_pkg::*;
(
	mia_in_if.sink     in_ch,
	input  logic       full,
	output logic       push,
	output item_t      item
);

	logic [DataW-1:0] a, b, sum, diff;
	logic             add_ovf, sub_ovf;

	assign a    = in_ch.operand_a;
	assign b    = in_ch.operand_b;
	assign sum  = a + b;
	assign diff = a - b;
	assign add_ovf = (a[DataW-1] ^ sum[DataW-1]) & (b[DataW-1] ^ sum[DataW-1]);
	assign sub_ovf = (a[DataW-1] ^ b[DataW-1]) & (a[DataW-1] ^ diff[DataW-1]);

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	always_comb begin
		item       = '0;
		item.kind  = K_SIMPLE;
		item.st    = ST_OK;
		unique case (op_t'(in_ch.action))
			OP_ADD, OP_ADDI: begin
				if (add_ovf) item.st = ST_OVF;
				else item.res = sum;
			end
			OP_SUB: begin
				if (sub_ovf) item.st = ST_OVF;
				else item.res = diff;
			end
			OP_MULT: begin
				item.kind = K_MULT;
				item.a    = a;
				item.b    = b;
			end
			OP_DIV: begin
				if (b == '0) begin
					item.st = ST_DIVZ;
				end else if (a == {1'b1, {(DataW-1){1'b0}}} && b == '1) begin
					item.st = ST_OVF;
				end else begin
					// The divider works on magnitudes; signs are restored at the end.
					item.kind  = K_DIV;
					item.a     = a[DataW-1] ? -a : a;
					item.b     = b[DataW-1] ? -b : b;
					item.neg_q = a[DataW-1] ^ b[DataW-1];
					item.neg_r = a[DataW-1];
				end
			end
			OP_AND: item.res = a & b;
			OP_OR:  item.res = a | b;
			default: item.res = a ^ b;
		endcase
	end

endmodule

>>> sv/mia_queue.sv
`timescale 1ns / 1ps

module mia_queue
	import mia_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	output logic  valid,
	input  logic  pop,
	output item_t rdata
);

	item_t      ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign rdata = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/mia_back.sv
`timescale 1ns / 1ps

module mia_back
	import mia_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       pop,
	mia_out_if.source  out_ch
);

	pipe_t                stg_s   [0:DivSteps];
	pipe_t                step_nxt [0:DivSteps];
	logic [DivSteps:0]    vld_s;
	logic                 adv;
	logic signed [2*DataW-1:0] prod;
	logic                 out_valid_q;
	logic [DataW-1:0]     res_q, hi_q, lo_q;
	status_t              st_q;
	pipe_t                last;

	// The whole pipeline moves together, so results keep their order.
	assign adv  = !out_valid_q || out_ch.ready;
	assign pop  = adv && q_valid;
	assign prod = $signed(q_item.a) * $signed(q_item.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DivSteps-1:0], q_valid};
		end
	end

	// One restoring division step per stage: shift in a dividend bit, try to subtract.
	always_comb begin
		logic [DataW:0] t, d;
		step_nxt[0]       = '0;
		step_nxt[0].kind  = q_item.kind;
		step_nxt[0].res   = q_item.res;
		step_nxt[0].st    = q_item.st;
		step_nxt[0].prod  = (q_item.kind == K_MULT) ? prod : '0;
		step_nxt[0].dq    = q_item.a;
		step_nxt[0].dvs   = q_item.b;
		step_nxt[0].neg_q = q_item.neg_q;
		step_nxt[0].neg_r = q_item.neg_r;
		for (int i = 1; i <= DivSteps; i++) begin
			t = {stg_s[i-1].rem, stg_s[i-1].dq[DataW-1]};
			d = t - {1'b0, stg_s[i-1].dvs};
			step_nxt[i]     = stg_s[i-1];
			step_nxt[i].rem = d[DataW] ? t[DataW-1:0] : d[DataW-1:0];
			step_nxt[i].dq  = {stg_s[i-1].dq[DataW-2:0], !d[DataW]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i <= DivSteps; i++) begin
				stg_s[i] <= step_nxt[i];
			end
		end
	end

	assign last = stg_s[DivSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= last.st;
			case (last.kind)
				K_MULT: begin
					res_q <= '0;
					hi_q  <= last.prod[2*DataW-1:DataW];
					lo_q  <= last.prod[DataW-1:0];
				end
				K_DIV: begin
					res_q <= '0;
					hi_q  <= last.neg_r ? -last.rem : last.rem;
					lo_q  <= last.neg_q ? -last.dq : last.dq;
				end
				default: begin
					res_q <= last.res;
					hi_q  <= '0;
					lo_q  <= '0;
				end
			endcase
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.result  = res_q;
	assign out_ch.hi_word = hi_q;
	assign out_ch.lo_word = lo_q;
	assign out_ch.status  = st_q;

endmodule

>>> sv/mips_integer_alu_top.sv
`timescale 1ns / 1ps
// A request passes the queue register, one multiply/setup stage, 32 division-step
// stages and one result stage; the pipelined divider sets the depth.
// Throughput: one request per cycle for every operation unless the output stalls.
// Back-pressure stalls the whole execution pipeline; a two-entry queue decouples the input.
// Reset: arst_n, asynchronous active low, clears the queue and all valid flags.
module mips_integer_alu_top
	import mia_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mia_in_if.sink    in_ch,
	mia_out_if.source out_ch
);

	logic  full, push, q_valid, pop;
	item_t w_item, q_item;

	mia_front u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.item  (w_item)
	);

	mia_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (w_item),
		.full   (full),
		.valid  (q_valid),
		.pop    (pop),
		.rdata  (q_item)
	);

	mia_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

>>> test/tb_mips_integer_alu_top.sv
`timescale 1ns / 1ps

module tb_mips_integer_alu_top;
	import mia_pkg::*;

	typedef struct packed {
		op_t         action;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] result;
		logic [31:0] hi_word;
		logic [31:0] lo_word;
		status_t     status;
	} alu_res_t;

	logic clk;
	logic arst_n;

	mia_in_if  in_ch();
	mia_out_if out_ch();

	mips_integer_alu_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	alu_req_t pending_reqs[$];
	alu_res_t expected_res[$];
	int       send_idle_pct;
	int       recv_stall_pct;
	int       hold_off_cycles = 0;
	int       hold_off_req = 0;
	int       hold_off_ack = 0;
	bit       hold_input;
	int       error_count = 0;
	longint   cycle_count = 0;

	function automatic alu_res_t compute_alu(alu_req_t r);
		alu_res_t    o;
		logic [31:0] s;
		logic [63:0] p;
		o = '0;
		o.status = ST_OK;
		case (r.action)
			OP_ADD, OP_ADDI: begin
				s = r.a + r.b;
				if (r.a[31] == r.b[31] && s[31] != r.a[31])
					o.status = ST_OVF;
				else
					o.result = s;
			end
			OP_SUB: begin
				s = r.a - r.b;
				if (r.a[31] != r.b[31] && s[31] != r.a[31])
					o.status = ST_OVF;
				else
					o.result = s;
			end
			OP_MULT: begin
				p = $signed({{32{r.a[31]}}, r.a}) * $signed({{32{r.b[31]}}, r.b});
				o.hi_word = p[63:32];
				o.lo_word = p[31:0];
			end
			OP_DIV: begin
				if (r.b == 32'd0)
					o.status = ST_DIVZ;
				else if (r.a == 32'h8000_0000 && r.b == 32'hFFFF_FFFF)
					o.status = ST_OVF;
				else begin
					o.lo_word = $signed(r.a) / $signed(r.b);
					o.hi_word = $signed(r.a) % $signed(r.b);
				end
			end
			OP_AND: o.result = r.a & r.b;
			OP_OR:  o.result = r.a | r.b;
			default: o.result = r.a ^ r.b;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'hFFFF_FFFF;
			3: v = 32'd0;
			4: v = $urandom_range(0, 20) - 10;
			5: v = $urandom & 32'hFFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic push_req(op_t op, logic [31:0] a, logic [31:0] b);
		alu_req_t r;
		r.action = op;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= '0;
			in_ch.operand_a <= '0;
			in_ch.operand_b <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_reqs.size() > 0 && !hold_input
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				alu_req_t r;
				r = pending_reqs.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.action <= r.action;
				in_ch.operand_a <= r.a;
				in_ch.operand_b <= r.b;
				expected_res.push_back(compute_alu(r));
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with an optional long hold-off counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_off_ack != hold_off_req) begin
			hold_off_ack <= hold_off_req;
			hold_off_cycles <= 200;
			out_ch.ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %0d", $time, out_ch.result,
					out_ch.hi_word, out_ch.lo_word, out_ch.status);
				error_count <= error_count + 1;
			end else begin
				alu_res_t e;
				e = expected_res.pop_front();
				if (e.result !== out_ch.result || e.hi_word !== out_ch.hi_word
						|| e.lo_word !== out_ch.lo_word || e.status !== out_ch.status) begin
					$display("%0t: expected %h %h %h %0d, got %h %h %h %0d", $time,
						e.result, e.hi_word, e.lo_word, e.status, out_ch.result,
						out_ch.hi_word, out_ch.lo_word, out_ch.status);
					error_count <= error_count + 1;
				end
			end
		end
		if (cycle_count > 2000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || in_ch.valid || expected_res.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		int opi;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_input = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: overflow edges, division corners, field extremes.
		push_req(OP_ADD, 32'h7FFF_FFFF, 32'd1);
		push_req(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
		push_req(OP_ADDI, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(OP_ADDI, 32'h7FFF_FFFF, 32'd1);
		push_req(OP_SUB, 32'd0, 32'h8000_0000);
		push_req(OP_SUB, 32'h8000_0000, 32'd1);
		push_req(OP_SUB, 32'hFFFF_FFFF, 32'h8000_0000);
		push_req(OP_MULT, 32'h8000_0000, 32'h8000_0000);
		push_req(OP_MULT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(OP_MULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(OP_DIV, 32'd7, 32'd0);
		push_req(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		push_req(OP_DIV, 32'hFFFF_FFF9, 32'd2);
		push_req(OP_DIV, 32'd7, 32'hFFFF_FFFE);
		push_req(OP_DIV, 32'h8000_0000, 32'd1);
		push_req(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(OP_AND, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		push_req(OP_OR, 32'd0, 32'h5A5A_5A5A);
		push_req(OP_XOR, 32'hFFFF_FFFF, 32'h0000_0000);
		push_req(OP_XOR, 32'h8000_0000, 32'h7FFF_FFFF);
		drain();

		// The receiver holds off while the sender keeps offering.
		hold_off_req = hold_off_req + 1;
		for (int i = 0; i < 60; i++)
			push_req(op_t'($urandom_range(0, 7)), rand_operand(), rand_operand());
		drain();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 10) : 0;
			recv_stall_pct = (ph == 2) ? 71 : ((ph == 3) ? 10 : 0);
			for (int i = 0; i < 430; i++) begin
				opi = $urandom_range(0, 7);
				push_req(op_t'(opi), rand_operand(), rand_operand());
			end
			drain();
			// The sender pauses here until every result is back.
		end

		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_res.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> mips_integer_alu_top.f
sv/mia_pkg.sv
sv/mia_if.sv
sv/mia_front.sv
sv/mia_queue.sv
sv/mia_back.sv
sv/mips_integer_alu_top.sv
test/tb_mips_integer_alu_top.sv
